FILE: hdl/rwm_pkg.sv
// shared widths and state types for the running window mean filter
package rwm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int MEAN_W   = 16;
  localparam int LEN_W    = 11;

  typedef enum logic [2:0] {
    R_IDLE  = 3'b001,
    R_SUB   = 3'b010,
    R_START = 3'b100
  } ring_state_t;

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_RUN  = 3'b010,
    D_DONE = 3'b100
  } div_state_t;

endpackage

FILE: hdl/rwm_sample_if.sv
// valid/ready channel carrying one input sample per beat
interface rwm_sample_if;
  logic                         valid;
  logic                         ready;
  logic [rwm_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

FILE: hdl/rwm_mean_if.sv
// valid/ready channel carrying one mean result per beat
interface rwm_mean_if;
  logic                       valid;
  logic                       ready;
  logic [rwm_pkg::MEAN_W-1:0] mean;

  modport source (output valid, output mean, input ready);
  modport sink   (input valid, input mean, output ready);
endinterface

FILE: hdl/rwm_ring.sv
// sample ring, pointers, running sum and fill count
module rwm_ring #(
  parameter int MAX_WINDOW = 1024,
  parameter int AW         = 10,
  parameter int SUM_W      = 27
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [rwm_pkg::LEN_W-1:0] cfg_data,
  rwm_sample_if.sink                sample_ch,
  output logic                      start,
  output logic [SUM_W-1:0]          sum,
  output logic [rwm_pkg::LEN_W-1:0] fill,
  input  logic                      div_ready
);

  localparam int LW      = rwm_pkg::LEN_W;
  localparam int SW      = rwm_pkg::SAMPLE_W;
  localparam int CW      = ((AW > LW) ? AW : LW) + 1;
  localparam int CAP_I   = (MAX_WINDOW > (2 ** LW) - 1) ? (2 ** LW) - 1 : MAX_WINDOW;
  localparam int RST_I   = (MAX_WINDOW < 1024) ? MAX_WINDOW : 1024;
  localparam logic [LW-1:0] LEN_CAP = LW'(CAP_I);
  localparam logic [LW-1:0] LEN_RST = LW'(RST_I);

  rwm_pkg::ring_state_t state;

  logic [SW-1:0] mem [MAX_WINDOW];
  logic [SW-1:0] rd_data;
  logic [AW-1:0] wi;
  logic [AW-1:0] oi;
  logic [LW-1:0] len;

  logic          accept;
  logic [CW-1:0] wi_inc;
  logic [CW-1:0] oi_inc;
  logic [AW-1:0] wi_next;
  logic [AW-1:0] oi_next;
  logic [LW-1:0] cfg_len;

  assign sample_ch.ready = (state == rwm_pkg::R_IDLE);
  assign accept          = sample_ch.valid && sample_ch.ready;
  assign start           = (state == rwm_pkg::R_START) && div_ready;

  always_comb begin
    wi_inc  = CW'(wi) + CW'(1);
    oi_inc  = CW'(oi) + CW'(1);
    wi_next = (wi_inc >= CW'(len)) ? '0 : wi_inc[AW-1:0];
    oi_next = (oi_inc >= CW'(len)) ? '0 : oi_inc[AW-1:0];
    if (cfg_data == '0) begin
      cfg_len = LW'(1);
    end else if (cfg_data > LEN_CAP) begin
      cfg_len = LEN_CAP;
    end else begin
      cfg_len = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rwm_pkg::R_IDLE;
      wi    <= '0;
      oi    <= '0;
      sum   <= '0;
      fill  <= '0;
      len   <= LEN_RST;
    end else if (cfg_we) begin
      len  <= cfg_len;
      wi   <= '0;
      oi   <= '0;
      sum  <= '0;
      fill <= '0;
    end else begin
      unique case (state)
        rwm_pkg::R_IDLE: begin
          if (accept) begin
            wi  <= wi_next;
            sum <= sum + SUM_W'(sample_ch.sample);
            if (fill < len) begin
              fill  <= fill + LW'(1);
              state <= rwm_pkg::R_START;
            end else begin
              oi    <= oi_next;
              state <= rwm_pkg::R_SUB;
            end
          end
        end
        rwm_pkg::R_SUB: begin
          sum   <= sum - SUM_W'(rd_data);
          state <= rwm_pkg::R_START;
        end
        rwm_pkg::R_START: begin
          if (div_ready) begin
            state <= rwm_pkg::R_IDLE;
          end
        end
        default: state <= rwm_pkg::R_IDLE;
      endcase
    end
  end

  // read of the oldest entry sees the value before this beat's write
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data      <= mem[oi_next];
      mem[wi_next] <= sample_ch.sample;
    end
  end

endmodule

FILE: hdl/rwm_div.sv
// bit-serial restoring divider with output register
module rwm_div #(
  parameter int SUM_W = 27
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [SUM_W-1:0]          dividend,
  input  logic [rwm_pkg::LEN_W-1:0] divisor,
  output logic                      ready,
  rwm_mean_if.source                mean_ch
);

  localparam int LW    = rwm_pkg::LEN_W;
  localparam int MW    = rwm_pkg::MEAN_W;
  localparam int CNT_W = $clog2(SUM_W + 1);

  rwm_pkg::div_state_t state;

  logic [CNT_W-1:0] cnt;
  logic [LW-1:0]    rem;
  logic [LW-1:0]    dvs;
  logic [SUM_W-1:0] quo;
  logic [MW-1:0]    omean;
  logic             ovalid;

  logic [LW:0]      rem_sh;
  logic [LW:0]      diff;
  logic             ge;
  logic [MW-1:0]    qsat;
  logic             load_out;

  always_comb begin
    rem_sh = {rem, quo[SUM_W-1]};
    diff   = rem_sh - {1'b0, dvs};
    ge     = (rem_sh >= {1'b0, dvs});
    qsat   = (|quo[SUM_W-1:MW]) ? '1 : quo[MW-1:0];
  end

  assign ready         = (state == rwm_pkg::D_IDLE);
  assign load_out      = (state == rwm_pkg::D_DONE) && (!ovalid || mean_ch.ready);
  assign mean_ch.valid = ovalid;
  assign mean_ch.mean  = omean;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= rwm_pkg::D_IDLE;
      ovalid <= 1'b0;
      cnt    <= '0;
    end else begin
      if (load_out) begin
        omean  <= qsat;
        ovalid <= 1'b1;
      end else if (mean_ch.ready) begin
        ovalid <= 1'b0;
      end
      unique case (state)
        rwm_pkg::D_IDLE: begin
          if (start) begin
            quo   <= dividend;
            dvs   <= divisor;
            rem   <= '0;
            cnt   <= '0;
            state <= rwm_pkg::D_RUN;
          end
        end
        rwm_pkg::D_RUN: begin
          rem <= ge ? diff[LW-1:0] : rem_sh[LW-1:0];
          quo <= {quo[SUM_W-2:0], ge};
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(SUM_W - 1)) begin
            state <= rwm_pkg::D_DONE;
          end
        end
        rwm_pkg::D_DONE: begin
          if (load_out) begin
            state <= rwm_pkg::D_IDLE;
          end
        end
        default: state <= rwm_pkg::D_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/running_window_mean.sv
// running window mean: top level joining the sample ring and the serial divider
// path from sample beat to mean valid: ring start state, divider run, divider done state and output
// register while filling, with the ring subtract state ahead of them once the window is full
// the ring may take a new sample while the one-bit-per-cycle divider is still busy with the last one
// a finished mean waits in the output register while the next sample is taken
// rst (synchronous) clears pointers, sum and fill count, window length to min(1024, MAX_WINDOW)
module running_window_mean #(
  parameter int MAX_WINDOW = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [rwm_pkg::LEN_W-1:0] cfg_data,
  rwm_sample_if.sink                sample_ch,
  rwm_mean_if.source                mean_ch
);

  localparam int AW    = $clog2(MAX_WINDOW);
  localparam int SUM_W = rwm_pkg::SAMPLE_W + $clog2(MAX_WINDOW + 1);

  logic                      start;
  logic                      div_ready;
  logic [SUM_W-1:0]          sum;
  logic [rwm_pkg::LEN_W-1:0] fill;

  rwm_ring #(
    .MAX_WINDOW (MAX_WINDOW),
    .AW         (AW),
    .SUM_W      (SUM_W)
  ) u_ring (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .sample_ch (sample_ch),
    .start     (start),
    .sum       (sum),
    .fill      (fill),
    .div_ready (div_ready)
  );

  rwm_div #(
    .SUM_W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .dividend (sum),
    .divisor  (fill),
    .ready    (div_ready),
    .mean_ch  (mean_ch)
  );

endmodule
